FILE: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 8'd1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd8;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd100;

    // Command codes, equal to the mode field codes
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_BIT   = 3'd6
    } t_cmd;

    localparam logic [2:0] MODE_RSVD = 3'd7;

    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  phase;
        logic [15:0] tick_count;
        logic [2:0]  bit_count;
        logic [7:0]  shift_reg;
        logic [7:0]  ack_tries;
        logic        scl;
        logic        sda;
        logic        nack;
        logic [7:0]  tx_data;
    } t_state;

    localparam t_state STATE_RST = '{
        cmd:        CMD_IDLE,
        phase:      3'd0,
        tick_count: 16'd0,
        bit_count:  3'd0,
        shift_reg:  8'd0,
        ack_tries:  8'd0,
        scl:        1'b1,
        sda:        1'b1,
        nack:       1'b0,
        tx_data:    8'd0
    };

endpackage

FILE: rtl/i2cm_if.sv
// Handshake channels of the I2C master bit engine: tick input, result output, config write.
`timescale 1ns / 1ps

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output mode, output tx_byte, output sda_in, input ready);
    modport sink   (input valid, input mode, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output rx_byte, output nack, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input rx_byte, input nack, output ready);
endinterface

interface i2cm_cfg_if import i2cm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/i2cm_cfg.sv
// Configuration registers: half period length and ack timeout.
`timescale 1ns / 1ps

module i2cm_cfg import i2cm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cm_cfg_if.sink      i_cfg,
    output logic [15:0]   o_half_period,
    output logic [7:0]    o_ack_limit
);

    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg.data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one
    assign o_half_period = (r_half_period == 16'd0) ? 16'd1 : r_half_period;
    assign o_ack_limit   = (r_ack_timeout == 8'd0)  ? 8'd1  : r_ack_timeout;

endmodule

FILE: rtl/i2cm_step.sv
// Next-state logic for one tick: command launch, tick count and phase sequencing.
`timescale 1ns / 1ps

module i2cm_step import i2cm_pkg::*; (
    input  t_state        i_st,
    input  logic [2:0]    i_mode,
    input  logic [7:0]    i_tx_byte,
    input  logic          i_sda_in,
    input  logic [15:0]   i_half_period,
    input  logic [7:0]    i_ack_limit,
    output t_state        o_st,
    output logic          o_done
);

    function automatic logic cur_bit(input t_state s);
        logic [2:0] idx;
        begin
            idx = 3'd7 - s.bit_count;
            if (s.cmd == CMD_WRITE) cur_bit = s.tx_data[idx];
            else                    cur_bit = s.tx_data[0];
        end
    endfunction

    // Apply the drive levels that a phase sets on entry
    function automatic t_state enter_phase(input t_state s);
        t_state r;
        begin
            r = s;
            case (s.cmd)
                CMD_START: begin
                    if (s.phase == 3'd0)      r.sda = 1'b1;
                    else if (s.phase == 3'd1) r.scl = 1'b1;
                    else if (s.phase == 3'd2) r.sda = 1'b0;
                    else                      r.scl = 1'b0;
                end
                CMD_STOP: begin
                    if (s.phase == 3'd0)      r.sda = 1'b0;
                    else if (s.phase == 3'd2) r.scl = 1'b0;
                    else if (s.phase == 3'd4) r.scl = 1'b1;
                    else if (s.phase == 3'd6) r.sda = 1'b1;
                end
                CMD_WRITE, CMD_BIT: begin
                    if (s.phase == 3'd0)      r.sda = cur_bit(s);
                    else if (s.phase == 3'd1) r.scl = 1'b1;
                    else if (s.phase == 3'd3) r.scl = 1'b0;
                end
                CMD_READ: begin
                    if (s.phase == 3'd0) begin
                        r.sda = 1'b1;
                        r.scl = 1'b1;
                    end else if (s.phase == 3'd4) begin
                        r.scl = 1'b0;
                    end
                end
                CMD_ACK: begin
                    if (s.phase == 3'd0) begin
                        r.sda = 1'b1;
                    end else begin
                        r.scl       = 1'b1;
                        r.ack_tries = 8'd0;
                    end
                end
                default: ;
            endcase
            enter_phase = r;
        end
    endfunction

    t_state      st;
    logic        fin;
    logic        mode_ok;
    logic [16:0] cnt_inc;
    logic [7:0]  tries_n;

    assign mode_ok = (i_mode != 3'(CMD_IDLE)) && (i_mode != MODE_RSVD);

    always_comb begin
        st      = i_st;
        fin     = 1'b0;
        cnt_inc = 17'd0;
        tries_n = 8'd0;

        if (st.cmd == CMD_IDLE && mode_ok) begin
            st.cmd        = t_cmd'(i_mode);
            st.phase      = 3'd0;
            st.tick_count = 16'd0;
            st.bit_count  = 3'd0;
            st.tx_data    = i_tx_byte;
            if (st.cmd == CMD_READ) st.shift_reg = 8'd0;
            st = enter_phase(st);
        end

        if (st.cmd != CMD_IDLE) begin
            cnt_inc = {1'b0, st.tick_count} + 17'd1;
            if (cnt_inc >= {1'b0, i_half_period}) begin
                st.tick_count = 16'd0;
                case (st.cmd)
                    CMD_START: begin
                        if (st.phase < 3'd3) begin
                            st.phase = st.phase + 3'd1;
                            st = enter_phase(st);
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (st.phase < 3'd7) begin
                            st.phase = st.phase + 3'd1;
                            st = enter_phase(st);
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    CMD_WRITE, CMD_BIT: begin
                        if (st.phase < 3'd3) begin
                            st.phase = st.phase + 3'd1;
                            st = enter_phase(st);
                        end else if (st.cmd == CMD_WRITE && st.bit_count < 3'd7) begin
                            st.bit_count = st.bit_count + 3'd1;
                            st.phase     = 3'd0;
                            st = enter_phase(st);
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (st.phase == 3'd1) st.shift_reg = {st.shift_reg[6:0], i_sda_in};
                        if (st.phase < 3'd4) begin
                            st.phase = st.phase + 3'd1;
                            st = enter_phase(st);
                        end else if (st.bit_count < 3'd7) begin
                            st.bit_count = st.bit_count + 3'd1;
                            st.phase     = 3'd0;
                            st = enter_phase(st);
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    CMD_ACK: begin
                        if (st.phase == 3'd0) begin
                            st.phase = 3'd1;
                            st = enter_phase(st);
                        end else begin
                            tries_n      = st.ack_tries + 8'd1;
                            st.ack_tries = tries_n;
                            // Finish on an ack or when the sample budget is spent
                            if (!i_sda_in || tries_n >= i_ack_limit) begin
                                st.scl  = 1'b0;
                                st.nack = i_sda_in;
                                fin     = 1'b1;
                            end
                        end
                    end
                    default: fin = 1'b1;
                endcase
                if (fin) begin
                    st.cmd   = CMD_IDLE;
                    st.phase = 3'd0;
                end
            end else begin
                st.tick_count = cnt_inc[15:0];
            end
        end
    end

    assign o_st   = st;
    assign o_done = fin;

endmodule

FILE: rtl/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: state register, result register and checks.
// A tick word's result is registered and shows in the cycle after the word is taken.
// Throughput: one tick word per cycle while results are taken; the step logic is a
// single pass from state to result register, which frees itself as it is taken.
// Reset (synchronous, active low): idle command, SCL and SDA released, counters and
// received byte cleared, half period 8 ticks, ack timeout 100 samples, no result pending.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core import i2cm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2cm_in_if.sink   i_in,
    i2cm_out_if.source o_out,
    i2cm_cfg_if.sink  i_cfg
);

    logic [15:0] half_period;
    logic [7:0]  ack_limit;
    t_state      r_state;
    t_state      n_state;
    logic        n_done;
    logic        in_acc;

    logic        r_out_valid;
    logic        r_scl;
    logic        r_sda;
    logic        r_busy;
    logic        r_done;
    logic [7:0]  r_rx_byte;
    logic        r_nack;

    i2cm_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .o_half_period (half_period),
        .o_ack_limit   (ack_limit)
    );

    i2cm_step u_step (
        .i_st          (r_state),
        .i_mode        (i_in.mode),
        .i_tx_byte     (i_in.tx_byte),
        .i_sda_in      (i_in.sda_in),
        .i_half_period (half_period),
        .i_ack_limit   (ack_limit),
        .o_st          (n_state),
        .o_done        (n_done)
    );

    // Take a new word whenever the result slot is empty or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) r_state <= n_state;
            if (in_acc) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_scl     <= n_state.scl;
            r_sda     <= n_state.sda;
            r_busy    <= (n_state.cmd != CMD_IDLE);
            r_done    <= n_done;
            r_rx_byte <= n_state.shift_reg;
            r_nack    <= n_state.nack;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.scl_out  = r_scl;
    assign o_out.sda_out  = r_sda;
    assign o_out.busy_res = r_busy;
    assign o_out.done_res = r_done;
    assign o_out.rx_byte  = r_rx_byte;
    assign o_out.nack     = r_nack;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_busy && r_done))
        else $error("result shows busy and done together");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cmd == CMD_IDLE |-> (r_state.phase == 3'd0 && r_state.tick_count == 16'd0))
        else $error("idle engine holds a phase or tick count");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.cmd == CMD_START || r_state.cmd == CMD_BIT) |-> r_state.phase <= 3'd3)
        else $error("start or bit command beyond its last phase");

    a_single_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.cmd == CMD_START || r_state.cmd == CMD_STOP ||
         r_state.cmd == CMD_ACK || r_state.cmd == CMD_BIT) |-> r_state.bit_count == 3'd0)
        else $error("bit counter moved outside a byte command");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_done) |=> r_state.cmd == CMD_IDLE)
        else $error("engine still busy after finishing a command");

endmodule
